### hdl/rht_pkg.sv
// Package for the reference-counted handle table.
// Types, codes and sizes shared by the interfaces, controller, datapath and top.
`timescale 1ns / 1ps
package rht_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int ID_W          = 16;
   localparam int ADDR_W        = 32;
   localparam int REFS_W        = 16;
   localparam int ENTRY_W       = ID_W + ADDR_W + REFS_W;

   localparam logic [REFS_W-1:0] REFS_MAX = '1;

   typedef enum logic [1:0] {
      MODE_REGISTER = 2'd0,
      MODE_RETAIN   = 2'd1,
      MODE_RELEASE  = 2'd2,
      MODE_LOOKUP   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_COMMIT
   } state_type;

   // one stored table entry
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [ADDR_W-1:0] address;
      logic [REFS_W-1:0] refs;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic done;
      logic out_busy;
   } stat_type;

   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   id_out;
      logic [ADDR_W-1:0] address_out;
      logic [REFS_W-1:0] ref_count;
      logic              freed;
   } rsp_type;

endpackage

### hdl/rht_req_if.sv
// Request channel of the handle table: valid/ready plus one operation item.
// Depends on rht_pkg.
`timescale 1ns / 1ps
interface rht_req_if import rht_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        mode;
   logic [ID_W-1:0]   item_id;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output mode, output item_id, output address, input ready);
   modport sink   (input valid, input mode, input item_id, input address, output ready);
endinterface

### hdl/rht_rsp_if.sv
// Response channel of the handle table: valid/ready plus one result item.
// Depends on rht_pkg.
`timescale 1ns / 1ps
interface rht_rsp_if import rht_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [ID_W-1:0]   id_out;
   logic [ADDR_W-1:0] address_out;
   logic [REFS_W-1:0] ref_count;
   logic              freed;

   modport source (output valid, output status, output id_out, output address_out,
                   output ref_count, output freed, input ready);
   modport sink   (input valid, input status, input id_out, input address_out,
                   input ref_count, input freed, output ready);
endinterface

### hdl/refcount_handle_table.sv
// Top level of the reference-counted handle table.
// Depends on rht_pkg, rht_req_if, rht_rsp_if, rht_ctrl, rht_dp (and rht_ram).
`timescale 1ns / 1ps
// Usage:
//  - req_chan (sink) takes one operation item: mode (register, retain,
//    release, lookup), item_id and address. rsp_chan (source) gives exactly
//    one result item per request: status, id_out, address_out, ref_count,
//    freed.
//  - Each item scans the entry RAM one entry per cycle from slot 0, looking
//    for the first free slot (register) or the first valid slot holding
//    item_id (the others). The scan stops at the first hit.
//  - The item is latched, slots are read and checked in turn, and a hit, or a
//    miss at the last slot, leads to commit. The single-read-port entry RAM
//    and its registered read set the one-entry-per-cycle pace.
//  - One item at a time: req_ready is high only while idle, so a new item is
//    not accepted until the last one has committed its result.
//  - The result sits in an output register; a new request is accepted while
//    it waits. If rsp_chan stalls, the next item finishes its scan and then
//    holds until the output register is taken.
//  - Reset (synchronous, active high) clears all valid bits and the handle
//    counter; the first registered handle is 1. Entry contents need no reset.
module refcount_handle_table import rht_pkg::*; (
   input logic         clock,
   input logic         reset,
   rht_req_if.sink     req_chan,
   rht_rsp_if.source   rsp_chan
);
   cmd_type  cmd;
   stat_type stat;
   rsp_type  rsp_data;

   rht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rht_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_mode    (req_chan.mode),
      .req_item_id (req_chan.item_id),
      .req_address (req_chan.address),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_data    (rsp_data)
   );

   // unpack the result register onto the channel
   assign rsp_chan.status      = rsp_data.status;
   assign rsp_chan.id_out      = rsp_data.id_out;
   assign rsp_chan.address_out = rsp_data.address_out;
   assign rsp_chan.ref_count   = rsp_data.ref_count;
   assign rsp_chan.freed       = rsp_data.freed;
endmodule

### hdl/rht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependency.
`timescale 1ns / 1ps
module rht_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### hdl/rht_ctrl.sv
// Controller of the handle table: sequences load, scan and commit of one item.
// Depends on rht_pkg.
`timescale 1ns / 1ps
module rht_ctrl import rht_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (stat.done) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (!stat.out_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
         end
         S_COMMIT: begin
            cmd.commit = !stat.out_busy;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end
endmodule

### hdl/rht_dp.sv
// Datapath of the handle table: entry RAM, valid bits, scan pointer,
// handle counter and the output register. Depends on rht_pkg and rht_ram.
`timescale 1ns / 1ps
module rht_dp import rht_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic [1:0]        req_mode,
   input  logic [ID_W-1:0]   req_item_id,
   input  logic [ADDR_W-1:0] req_address,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data
);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   // latched request
   mode_type          mode_ff;
   logic [ID_W-1:0]   item_id_ff;
   logic [ADDR_W-1:0] address_ff;

   // scan pointer
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] idx_d_ff;
   logic             issued_all_ff, issued_all_in;
   logic             chk_ff, chk_in;

   // scan result
   logic             found_ok_ff, found_ok_in;
   logic [IDX_W-1:0] slot_ff;
   entry_type        found_ff;

   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [ID_W-1:0]          next_handle_ff, next_handle_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic             ram_rd_en, ram_wr_en;
   logic [ENTRY_W-1:0] ram_rd_data;
   entry_type        rd_entry, wr_entry;
   logic             hit, miss;
   logic [REFS_W-1:0] new_refs;
   logic [ID_W-1:0]   new_handle;

   assign ram_rd_en = cmd.scan && !issued_all_ff;
   assign rd_entry  = entry_type'(ram_rd_data);

   rht_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (ENTRY_W'(wr_entry)),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   // register needs a free slot, the others a valid slot with a matching id
   always_comb begin
      if (mode_ff == MODE_REGISTER) begin
         hit = chk_ff && !valid_ff[idx_d_ff];
      end else begin
         hit = chk_ff && valid_ff[idx_d_ff] && (rd_entry.id == item_id_ff);
      end
      miss = chk_ff && !hit && (idx_d_ff == LAST_IDX);
   end

   assign stat.done     = hit || miss;
   assign stat.out_busy = rsp_valid_ff && !rsp_ready;

   always_comb begin
      idx_in        = idx_ff;
      issued_all_in = issued_all_ff;
      chk_in        = 1'b0;
      found_ok_in   = found_ok_ff;
      if (cmd.load) begin
         idx_in        = '0;
         issued_all_in = 1'b0;
         found_ok_in   = 1'b0;
      end else if (cmd.scan) begin
         if (hit) found_ok_in = 1'b1;
         if (!issued_all_ff) begin
            chk_in = 1'b1;
            if (idx_ff == LAST_IDX) begin
               issued_all_in = 1'b1;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
      end
   end

   // update of the entry acted on and the result item
   always_comb begin
      new_handle     = next_handle_ff + 1'b1;
      next_handle_in = next_handle_ff;
      valid_in       = valid_ff;
      ram_wr_en      = 1'b0;
      wr_entry       = found_ff;
      new_refs       = found_ff.refs;
      rsp_in         = '0;
      rsp_in.status  = ST_OK;
      case (mode_ff)
         MODE_RETAIN:  new_refs = (found_ff.refs == REFS_MAX) ? found_ff.refs
                                                             : found_ff.refs + 1'b1;
         MODE_RELEASE: new_refs = (found_ff.refs == '0) ? found_ff.refs
                                                       : found_ff.refs - 1'b1;
         default:      new_refs = found_ff.refs;
      endcase
      if (mode_ff == MODE_REGISTER) begin
         if (found_ok_ff) begin
            wr_entry.id      = new_handle;
            wr_entry.address = address_ff;
            wr_entry.refs    = REFS_W'(1);
            rsp_in.id_out      = new_handle;
            rsp_in.address_out = address_ff;
            rsp_in.ref_count   = REFS_W'(1);
            if (cmd.commit) begin
               ram_wr_en         = 1'b1;
               valid_in[slot_ff] = 1'b1;
               next_handle_in    = new_handle;
            end
         end else begin
            rsp_in.status = ST_FULL;
         end
      end else begin
         rsp_in.id_out = item_id_ff;
         if (found_ok_ff) begin
            wr_entry.refs      = new_refs;
            rsp_in.address_out = found_ff.address;
            rsp_in.ref_count   = new_refs;
            if (mode_ff == MODE_RELEASE && new_refs == '0) rsp_in.freed = 1'b1;
            if (cmd.commit && mode_ff != MODE_LOOKUP) begin
               ram_wr_en = 1'b1;
               if (rsp_in.freed) valid_in[slot_ff] = 1'b0;
            end
         end else begin
            rsp_in.status = ST_NOT_FOUND;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff         <= '0;
         issued_all_ff  <= 1'b1;
         chk_ff         <= 1'b0;
         found_ok_ff    <= 1'b0;
         valid_ff       <= '0;
         next_handle_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         idx_ff         <= idx_in;
         issued_all_ff  <= issued_all_in;
         chk_ff         <= chk_in;
         found_ok_ff    <= found_ok_in;
         valid_ff       <= valid_in;
         next_handle_ff <= next_handle_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff    <= mode_type'(req_mode);
         item_id_ff <= req_item_id;
         address_ff <= req_address;
      end
      if (ram_rd_en) idx_d_ff <= idx_ff;
      if (cmd.scan && hit) begin
         slot_ff  <= idx_d_ff;
         found_ff <= rd_entry;
      end
      if (cmd.commit) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && !rsp_ready))
      else $error("commit while result still stalled");

   a_valid_only_on_commit: assert property (@(posedge clock) disable iff (reset)
      !cmd.commit |=> $stable(valid_ff))
      else $error("valid bits changed outside commit");

   a_ram_one_port: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("entry RAM read and written together");

   a_freed_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_ff.freed || (rsp_ff.ref_count == '0 && rsp_ff.status == ST_OK)))
      else $error("freed result with nonzero count or bad status");
endmodule
